// ----- hw/rtl/prc_pkg.sv -----
package prc_pkg;

  // Coordinate and coefficient formats
  localparam int COORD_W    = 32;
  localparam int COEF_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int ANGLE_W    = 16;
  localparam int DIMS_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  // Datapath widths
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + COEF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SHR_W  = ACC_W - FRAC_W;
  localparam int RES_W  = SHR_W + 1;

  // Cycles from an accepted transaction to its result strobe
  localparam int PIPE_LAT = 4;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0]  COEF_ONE  = COEF_W'(1 << FRAC_W);

  localparam logic [DIMS_W-1:0] DIMS_RESET      = DIMS_W'(2);
  localparam logic [DIMS_W-1:0] DIMS_ROTATE_MIN = DIMS_W'(2);

  // Series evaluation of the coefficients (Q63 fixed point)
  localparam int          SER_W     = 64;
  localparam int          SER_TERMS = 24;
  localparam logic [63:0] PI_Q48    = 64'h0003_243F_6A88_85A3;
  localparam logic [11:0] PI_FRAC   = 12'h8D3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_ANGLE,
    REG_STATE_DIMS
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_first;
    logic signed [COORD_W-1:0] coord_second;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rot_first;
    logic signed [COORD_W-1:0] rot_second;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_c;
    logic signed [COEF_W-1:0] sin_c;
  } coef_t;

endpackage

// ----- hw/rtl/plane_rotation_about_center.sv -----
// Rotates each point (coord_first, coord_second), signed Q16.16, about the
// configured center by the configured binary angle and saturates the result.
// A transaction is taken when start is high and busy is low; one point can
// enter every cycle. Its result shows on out_item for one cycle with
// out_strobe high, through a 4-stage pipeline (offset, multiply, sum and
// round, add center and clip). Results cannot be held off, so they must be
// captured when out_strobe is high. A write to the angle register
// recomputes cosine and sine with a bit-serial multiplier and divider; busy
// stays high until the update is done, and no point is taken meanwhile.
// Other register writes take effect at once. A state_dims value below two
// passes points through unchanged.
module plane_rotation_about_center (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  prc_pkg::in_item_t                in_item,
  output logic                             out_strobe,
  output prc_pkg::out_item_t               out_item,
  input  logic                             cfg_we,
  input  prc_pkg::cfg_reg_t                cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = prc_pkg::COORD_W;
  localparam int DW = prc_pkg::DIFF_W;
  localparam int PW = prc_pkg::PROD_W;
  localparam int AW = prc_pkg::ACC_W;
  localparam int SH = prc_pkg::SHR_W;
  localparam int RW = prc_pkg::RES_W;
  localparam int FW = prc_pkg::FRAC_W;
  localparam logic [AW-1:0] RND_HALF = AW'(1) << (FW - 1);

  // Configuration registers
  logic [CW-1:0]                cx_r;
  logic [CW-1:0]                cy_r;
  logic [prc_pkg::DIMS_W-1:0]   dims_r;
  logic                         cx_we;
  logic                         cy_we;
  logic                         angle_we;
  logic                         dims_we;
  prc_pkg::coef_t               coef;

  // Pipeline
  logic                         in_accept;
  logic                         byp_in;
  logic [DW-1:0]                x0_ext;
  logic [DW-1:0]                x1_ext;
  logic [DW-1:0]                dx_nxt;
  logic [DW-1:0]                dy_nxt;
  logic                         v1_r;
  logic                         v2_r;
  logic                         v3_r;
  logic                         out_strobe_r;
  logic                         byp1_r;
  logic                         byp2_r;
  logic                         byp3_r;
  logic [DW-1:0]                dx1_r;
  logic [DW-1:0]                dy1_r;
  logic signed [prc_pkg::COEF_W-1:0] c_eff;
  logic signed [prc_pkg::COEF_W-1:0] s_eff;
  logic [PW-1:0]                p_cdx_r;
  logic [PW-1:0]                p_sdy_r;
  logic [PW-1:0]                p_sdx_r;
  logic [PW-1:0]                p_cdy_r;
  logic [AW-1:0]                acc0;
  logic [AW-1:0]                acc1;
  logic [SH-1:0]                sh0_r;
  logic [SH-1:0]                sh1_r;
  logic [CW-1:0]                cx_eff;
  logic [CW-1:0]                cy_eff;
  logic [RW-1:0]                res0;
  logic [RW-1:0]                res1;
  logic                         fits0;
  logic                         fits1;
  prc_pkg::out_item_t           out_nxt;
  prc_pkg::out_item_t           out_item_r;

  // Register write decode
  always_comb begin
    cx_we    = 1'b0;
    cy_we    = 1'b0;
    angle_we = 1'b0;
    dims_we  = 1'b0;
    unique case (cfg_index)
      prc_pkg::REG_CENTER_X:   cx_we    = cfg_we;
      prc_pkg::REG_CENTER_Y:   cy_we    = cfg_we;
      prc_pkg::REG_ANGLE:      angle_we = cfg_we;
      prc_pkg::REG_STATE_DIMS: dims_we  = cfg_we;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      dims_r <= prc_pkg::DIMS_RESET;
    end else begin
      if (cx_we) begin
        cx_r <= cfg_data[CW-1:0];
      end
      if (cy_we) begin
        cy_r <= cfg_data[CW-1:0];
      end
      if (dims_we) begin
        dims_r <= cfg_data[prc_pkg::DIMS_W-1:0];
      end
    end
  end

  prc_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .angle_we (angle_we),
    .angle    (cfg_data[prc_pkg::ANGLE_W-1:0]),
    .coef     (coef),
    .busy     (busy)
  );

  assign in_accept = start && !busy;

  // Stage 1: offsets from the center; bypass feeds the raw point
  assign byp_in = dims_r < prc_pkg::DIMS_ROTATE_MIN;
  assign x0_ext = {in_item.coord_first[CW-1], in_item.coord_first};
  assign x1_ext = {in_item.coord_second[CW-1], in_item.coord_second};
  assign dx_nxt = byp_in ? x0_ext : (x0_ext - {cx_r[CW-1], cx_r});
  assign dy_nxt = byp_in ? x1_ext : (x1_ext - {cy_r[CW-1], cy_r});

  // Stage 2: bypass uses an identity rotation
  assign c_eff = byp1_r ? prc_pkg::COEF_ONE : coef.cos_c;
  assign s_eff = byp1_r ? '0 : coef.sin_c;

  // Stage 3: combine, round half up, drop the fraction
  assign acc0 = {p_cdx_r[PW-1], p_cdx_r} - {p_sdy_r[PW-1], p_sdy_r} + RND_HALF;
  assign acc1 = {p_sdx_r[PW-1], p_sdx_r} + {p_cdy_r[PW-1], p_cdy_r} + RND_HALF;

  // Stage 4: add the center back and clip
  assign cx_eff = byp3_r ? '0 : cx_r;
  assign cy_eff = byp3_r ? '0 : cy_r;
  assign res0   = {sh0_r[SH-1], sh0_r} + {{(RW-CW){cx_eff[CW-1]}}, cx_eff};
  assign res1   = {sh1_r[SH-1], sh1_r} + {{(RW-CW){cy_eff[CW-1]}}, cy_eff};
  assign fits0  = (&res0[RW-1:CW-1]) || !(|res0[RW-1:CW-1]);
  assign fits1  = (&res1[RW-1:CW-1]) || !(|res1[RW-1:CW-1]);

  always_comb begin
    out_nxt.rot_first  = fits0 ? res0[CW-1:0] :
                         (res0[RW-1] ? prc_pkg::COORD_MIN : prc_pkg::COORD_MAX);
    out_nxt.rot_second = fits1 ? res1[CW-1:0] :
                         (res1[RW-1] ? prc_pkg::COORD_MIN : prc_pkg::COORD_MAX);
    out_nxt.saturated  = !fits0 || !fits1;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= in_accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_strobe_r <= v3_r;
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    byp1_r     <= byp_in;
    dx1_r      <= dx_nxt;
    dy1_r      <= dy_nxt;
    byp2_r     <= byp1_r;
    p_cdx_r    <= $signed(c_eff) * $signed(dx1_r);
    p_sdy_r    <= $signed(s_eff) * $signed(dy1_r);
    p_sdx_r    <= $signed(s_eff) * $signed(dx1_r);
    p_cdy_r    <= $signed(c_eff) * $signed(dy1_r);
    byp3_r     <= byp2_r;
    sh0_r      <= acc0[AW-1:FW];
    sh1_r      <= acc1[AW-1:FW];
    out_item_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ----- hw/rtl/prc_coef.sv -----
module prc_coef (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          angle_we,
  input  logic [prc_pkg::ANGLE_W-1:0]   angle,
  output prc_pkg::coef_t                coef,
  output logic                          busy
);

  localparam int SW      = prc_pkg::SER_W;
  localparam int CNT_W   = $clog2(SW);
  localparam int OCT_W   = prc_pkg::ANGLE_W - 2;
  localparam int BASE_W  = OCT_W;
  localparam int PF_W    = BASE_W + 12;
  localparam int PFRAC_W = PF_W - 16;
  localparam int DIV_W   = 12;
  localparam int K_W     = 6;
  localparam int ITER_W  = 5;
  localparam int RND_W   = SW - 47;
  localparam logic [OCT_W-1:0] HALF_OCT = OCT_W'(1 << (OCT_W - 1));
  localparam logic [OCT_W:0]   QUARTER  = (OCT_W + 1)'(1 << OCT_W);
  localparam logic [SW-1:0]    Q63_ONE  = SW'(1) << (SW - 1);
  localparam logic [SW-1:0]    RND_HALF = SW'(1) << 46;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T2_MUL,
    ST_SER_INIT,
    ST_SER_TEST,
    ST_TERM_MUL,
    ST_TERM_DIV,
    ST_SER_END,
    ST_MAP
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SW-1:0]          mul_a_r;
  logic [SW-1:0]          mul_b_r;
  logic [SW-1:0]          prod_hi_r;
  logic [SW-1:0]          prod_lo_r;
  logic [SW-1:0]          t_r;
  logic [SW-1:0]          t2_r;
  logic [SW-1:0]          term_r;
  logic [SW-1:0]          sum_r;
  logic [K_W-1:0]         k_r;
  logic [ITER_W-1:0]      iter_r;
  logic                   odd_r;
  logic [DIV_W-1:0]       rem_r;
  logic [RND_W-1:0]       cv_r;
  logic [RND_W-1:0]       sv_r;
  logic [1:0]             quad_r;
  logic                   swap_r;
  logic [PFRAC_W-1:0]     pfrac_r;
  prc_pkg::coef_t         coef_r;

  logic [OCT_W-1:0]       oct_in;
  logic                   swap_in;
  logic [BASE_W-1:0]      base_in;
  logic [PF_W-1:0]        pfrac_full;
  logic [SW:0]            mul_sum;
  logic [SW-1:0]          prod_hi_fin;
  logic [SW-1:0]          prod_lo_fin;
  logic [SW-1:0]          mul_q63;
  logic                   cnt_last;
  logic [DIV_W-1:0]       k_ext;
  logic [DIV_W-1:0]       div_d;
  logic [DIV_W:0]         div_trial;
  logic                   div_ge;
  logic [DIV_W-1:0]       div_rem;
  logic [SW-1:0]          quot_fin;
  logic [SW-1:0]          sum_upd;
  logic [SW-1:0]          t_fin;
  logic [SW-1:0]          rnd_sum;
  logic [RND_W-1:0]       rnd_val;
  logic signed [prc_pkg::COEF_W-1:0] c0;
  logic signed [prc_pkg::COEF_W-1:0] s0;

  // Fold the angle into the first octant
  assign oct_in     = angle[OCT_W-1:0];
  assign swap_in    = oct_in > HALF_OCT;
  assign base_in    = swap_in ? BASE_W'(QUARTER - {1'b0, oct_in}) : oct_in;
  assign pfrac_full = PF_W'(base_in) * PF_W'(prc_pkg::PI_FRAC);

  // Shift-add multiplier, one multiplier bit per cycle
  assign mul_sum     = {1'b0, prod_hi_r} + (mul_b_r[0] ? {1'b0, mul_a_r} : '0);
  assign prod_hi_fin = mul_sum[SW:1];
  assign prod_lo_fin = {mul_sum[0], prod_lo_r[SW-1:1]};
  assign mul_q63     = {prod_hi_fin[SW-2:0], prod_lo_fin[SW-1]};
  assign cnt_last    = (cnt_r == '1);
  assign t_fin       = prod_lo_fin + SW'(pfrac_r);

  // Restoring divider by (k+1)(k+2), one quotient bit per cycle
  assign k_ext     = DIV_W'(k_r);
  assign div_d     = DIV_W'((k_ext + DIV_W'(1)) * (k_ext + DIV_W'(2)));
  assign div_trial = {rem_r, term_r[SW-1]};
  assign div_ge    = div_trial >= {1'b0, div_d};
  assign div_rem   = div_ge ? DIV_W'(div_trial - {1'b0, div_d}) : div_trial[DIV_W-1:0];
  assign quot_fin  = {term_r[SW-2:0], div_ge};
  assign sum_upd   = iter_r[0] ? (sum_r + quot_fin) : (sum_r - quot_fin);

  // Round Q63 to Q16
  assign rnd_sum = sum_r + RND_HALF;
  assign rnd_val = rnd_sum[SW-1:47];

  assign c0 = swap_r ? {1'b0, sv_r} : {1'b0, cv_r};
  assign s0 = swap_r ? {1'b0, cv_r} : {1'b0, sv_r};

  // Sequencer: t, t^2, then cosine and sine series
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      coef_r.cos_c <= prc_pkg::COEF_ONE;
      coef_r.sin_c <= '0;
    end else if (angle_we) begin
      quad_r    <= angle[prc_pkg::ANGLE_W-1:OCT_W];
      swap_r    <= swap_in;
      pfrac_r   <= pfrac_full[PF_W-1:16];
      mul_a_r   <= SW'(base_in);
      mul_b_r   <= prc_pkg::PI_Q48;
      prod_hi_r <= '0;
      cnt_r     <= '0;
      state_r   <= ST_T_MUL;
    end else begin
      unique case (state_r) inside
        ST_IDLE: begin
        end
        ST_T_MUL, ST_T2_MUL, ST_TERM_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (!cnt_last) begin
            prod_hi_r <= prod_hi_fin;
            prod_lo_r <= prod_lo_fin;
            mul_b_r   <= mul_b_r >> 1;
          end else if (state_r == ST_T_MUL) begin
            t_r       <= t_fin;
            mul_a_r   <= t_fin;
            mul_b_r   <= t_fin;
            prod_hi_r <= '0;
            state_r   <= ST_T2_MUL;
          end else if (state_r == ST_T2_MUL) begin
            t2_r    <= mul_q63;
            odd_r   <= 1'b0;
            state_r <= ST_SER_INIT;
          end else begin
            term_r  <= mul_q63;
            rem_r   <= '0;
            state_r <= ST_TERM_DIV;
          end
        end
        ST_SER_INIT: begin
          term_r  <= odd_r ? t_r : Q63_ONE;
          sum_r   <= odd_r ? t_r : Q63_ONE;
          k_r     <= odd_r ? K_W'(1) : '0;
          iter_r  <= '0;
          state_r <= ST_SER_TEST;
        end
        ST_SER_TEST: begin
          if ((iter_r < ITER_W'(prc_pkg::SER_TERMS)) && (term_r != '0)) begin
            mul_a_r   <= term_r;
            mul_b_r   <= t2_r;
            prod_hi_r <= '0;
            cnt_r     <= '0;
            state_r   <= ST_TERM_MUL;
          end else begin
            state_r <= ST_SER_END;
          end
        end
        ST_TERM_DIV: begin
          rem_r  <= div_rem;
          term_r <= quot_fin;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_last) begin
            sum_r   <= sum_upd;
            k_r     <= k_r + K_W'(2);
            iter_r  <= iter_r + 1'b1;
            state_r <= ST_SER_TEST;
          end
        end
        ST_SER_END: begin
          if (!odd_r) begin
            cv_r    <= rnd_val;
            odd_r   <= 1'b1;
            state_r <= ST_SER_INIT;
          end else begin
            sv_r    <= rnd_val;
            state_r <= ST_MAP;
          end
        end
        ST_MAP: begin
          // Quadrant of the angle
          case (quad_r)
            2'd0: begin
              coef_r.cos_c <= c0;
              coef_r.sin_c <= s0;
            end
            2'd1: begin
              coef_r.cos_c <= -s0;
              coef_r.sin_c <= c0;
            end
            2'd2: begin
              coef_r.cos_c <= -c0;
              coef_r.sin_c <= -s0;
            end
            default: begin
              coef_r.cos_c <= s0;
              coef_r.sin_c <= -c0;
            end
          endcase
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign coef = coef_r;
  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hw/rtl/prc_checker.sv -----
module prc_assert_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input prc_pkg::out_item_t   out_item,
  input logic                 cfg_we,
  input prc_pkg::cfg_reg_t    cfg_index
);

  // Every accepted transaction yields a result after the pipeline latency
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(prc_pkg::PIPE_LAT) out_strobe)
    else $error("accepted transaction produced no result");

  // No result without a matching transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, prc_pkg::PIPE_LAT))
    else $error("result strobe without an accepted transaction");

  // Coefficient update only follows an angle write
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(cfg_we && (cfg_index == prc_pkg::REG_ANGLE)))
    else $error("busy rose without an angle write");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_index == prc_pkg::REG_ANGLE)) |=> busy)
    else $error("angle write did not start a coefficient update");

  // A clipped result sits at a range limit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.saturated) |->
      ((out_item.rot_first == prc_pkg::COORD_MAX) ||
       (out_item.rot_first == prc_pkg::COORD_MIN) ||
       (out_item.rot_second == prc_pkg::COORD_MAX) ||
       (out_item.rot_second == prc_pkg::COORD_MIN)))
    else $error("saturated flag without a clipped coordinate");

endmodule

bind plane_rotation_about_center prc_assert_checker u_prc_checker (.*);
